// ----- hw/rtl/sbsh_pkg.sv -----
// Shared types, constants and the round-constant table for the SHA-256 byte hasher.
package sbsh_pkg;

  localparam int unsigned NUM_WORDS = 8;
  localparam int unsigned WIN_WORDS = 16;
  localparam logic [7:0]  PAD_MARK_BYTE = 8'h80;
  localparam logic [5:0]  LEN_START = 6'd56;
  localparam logic [5:0]  LAST_SLOT = 6'd63;

  typedef struct packed {
    logic       kind;
    logic [7:0] msg_byte;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_item_t;

  typedef enum logic {
    KIND_DATA   = 1'b0,
    KIND_FINISH = 1'b1
  } item_kind_t;

  typedef logic [NUM_WORDS-1:0][31:0] chain_t;
  typedef logic [WIN_WORDS-1:0][31:0] window_t;

  // core control from the sequencer
  typedef struct packed {
    logic       shift;
    logic [7:0] data;
    logic       start;
    logic       init;
  } core_ctl_t;

  typedef enum logic [1:0] {
    CORE_IDLE,
    CORE_ROUND,
    CORE_ADD
  } core_st_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD_MARK,
    ST_PAD_ZERO,
    ST_PAD_LEN,
    ST_COMP,
    ST_FLUSH
  } seq_st_t;

  // h7 first so that index 0 is h0
  localparam chain_t INIT_HASH = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  function automatic logic [31:0] round_k(input logic [5:0] idx);
    logic [31:0] k;
    case (idx)
      6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

endpackage

// ----- hw/rtl/sbsh_core.sv -----
// SHA-256 compression engine: byte-loaded message window, one round per cycle.
module sbsh_core (
  input  logic              clk,
  input  logic              rst,
  input  sbsh_pkg::core_ctl_t ctl,
  output logic              done,
  output sbsh_pkg::chain_t  chain
);
  import sbsh_pkg::*;

  core_st_t    st, st_next;
  logic [5:0]  rnd;
  window_t     w, w_next;
  chain_t      v, v_next;
  logic [31:0] t1, t2, w_new;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] ssig0(input logic [31:0] x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  always_comb begin
    st_next = st;
    case (st)
      CORE_IDLE:  if (ctl.start) st_next = CORE_ROUND;
      CORE_ROUND: if (rnd == LAST_SLOT) st_next = CORE_ADD;
      CORE_ADD:   st_next = CORE_IDLE;
      default:    st_next = CORE_IDLE;
    endcase
  end

  // round datapath
  always_comb begin
    t1 = v[7] + bsig1(v[4]) + ((v[4] & v[5]) ^ (~v[4] & v[6])) + round_k(rnd) + w[0];
    t2 = bsig0(v[0]) + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
    w_new = ssig1(w[14]) + w[9] + ssig0(w[1]) + w[0];
  end

  always_comb begin
    w_next = w;
    v_next = v;
    done = 1'b0;
    case (st)
      CORE_IDLE: begin
        if (ctl.shift) begin
          for (int i = 0; i < WIN_WORDS - 1; i++) begin
            w_next[i] = {w[i][23:0], w[i+1][31:24]};
          end
          w_next[WIN_WORDS-1] = {w[WIN_WORDS-1][23:0], ctl.data};
        end
        if (ctl.start) v_next = chain;
      end
      CORE_ROUND: begin
        for (int i = 0; i < WIN_WORDS - 1; i++) begin
          w_next[i] = w[i+1];
        end
        w_next[WIN_WORDS-1] = w_new;
        v_next = {v[6:4], v[3] + t1, v[2:0], t1 + t2};
      end
      CORE_ADD: done = 1'b1;
      default: done = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= CORE_IDLE;
      rnd <= '0;
      chain <= INIT_HASH;
    end else begin
      st <= st_next;
      if (st == CORE_ROUND) rnd <= rnd + 6'd1;
      else rnd <= '0;
      if (st == CORE_ADD) begin
        for (int k = 0; k < NUM_WORDS; k++) begin
          chain[k] <= chain[k] + v[k];
        end
      end else if (ctl.init) begin
        chain <= INIT_HASH;
      end
    end
  end

  always_ff @(posedge clk) begin
    w <= w_next;
    v <= v_next;
  end

endmodule

// ----- hw/rtl/sbsh_out.sv -----
// Digest output buffer: holds the eight words and hands them out in order.
module sbsh_out (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  sbsh_pkg::chain_t   words,
  output logic               busy,
  output logic               out_valid,
  input  logic               out_ready,
  output sbsh_pkg::out_item_t out_data
);
  import sbsh_pkg::*;

  chain_t     dig;
  logic [2:0] idx;
  logic       vld;

  assign busy = vld;
  assign out_valid = vld;
  assign out_data.digest_word = dig[0];
  assign out_data.word_index = idx;
  assign out_data.last_word = (idx == 3'd7);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
      idx <= '0;
    end else if (load && !vld) begin
      vld <= 1'b1;
      idx <= '0;
    end else if (vld && out_ready) begin
      idx <= idx + 3'd1;
      if (idx == 3'd7) vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load && !vld) begin
      dig <= words;
    end else if (vld && out_ready) begin
      dig <= {32'h0, dig[NUM_WORDS-1:1]};
    end
  end

endmodule

// ----- hw/rtl/sha256_byte_stream_hasher.sv -----
// Top level of the SHA-256 byte stream hasher: padding sequencer, core and digest buffer.
//
//   channel | handshake             | payload
//   in      | in_valid / in_ready   | in_data  (kind, msg_byte)
//   out     | out_valid / out_ready | out_data (digest_word, word_index, last_word)
//
// A data request is taken only in idle; the 64th byte of a block starts a compression in
// the single round unit, which runs every round and then adds its result into the chain.
// A finish request feeds padding and length bytes into the window, runs one or two
// compressions, then parks the digest in the output buffer and returns to idle.
// Reset is synchronous; the output buffer drains independently of new input, and a
// following finish waits only if the previous digest has not been fully taken.
module sha256_byte_stream_hasher (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  sbsh_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output sbsh_pkg::out_item_t out_data
);
  import sbsh_pkg::*;

  seq_st_t     state, state_next, ret, ret_next;
  logic [5:0]  fill, fill_next;
  logic [54:0] blocks, blocks_next;
  logic [63:0] len, len_next;
  logic        acc;
  logic        core_done;
  logic        out_busy;
  logic        out_load;
  core_ctl_t   ctl;
  chain_t      chain;

  assign in_ready = (state == ST_IDLE);
  assign acc = in_valid && in_ready;

  always_comb begin
    state_next = state;
    ret_next = ret;
    case (state)
      ST_IDLE: begin
        if (acc) begin
          if (in_data.kind == KIND_FINISH) begin
            state_next = ST_PAD_MARK;
          end else if (fill == LAST_SLOT) begin
            state_next = ST_COMP;
            ret_next = ST_IDLE;
          end
        end
      end
      ST_PAD_MARK: begin
        state_next = ST_PAD_ZERO;
        if (fill == LAST_SLOT) begin
          state_next = ST_COMP;
          ret_next = ST_PAD_ZERO;
        end
      end
      ST_PAD_ZERO: begin
        if (fill == LEN_START) begin
          state_next = ST_PAD_LEN;
        end else if (fill == LAST_SLOT) begin
          state_next = ST_COMP;
          ret_next = ST_PAD_ZERO;
        end
      end
      ST_PAD_LEN: begin
        if (fill == LAST_SLOT) begin
          state_next = ST_COMP;
          ret_next = ST_FLUSH;
        end
      end
      ST_COMP:  if (core_done) state_next = ret;
      ST_FLUSH: if (!out_busy) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl = '0;
    out_load = 1'b0;
    fill_next = fill;
    blocks_next = blocks;
    len_next = len;
    case (state)
      ST_IDLE: begin
        if (acc) begin
          if (in_data.kind == KIND_FINISH) begin
            len_next = {blocks, fill, 3'b000};
          end else begin
            ctl.shift = 1'b1;
            ctl.data = in_data.msg_byte;
            ctl.start = (fill == LAST_SLOT);
            fill_next = fill + 6'd1;
            if (fill == LAST_SLOT) blocks_next = blocks + 55'd1;
          end
        end
      end
      ST_PAD_MARK: begin
        ctl.shift = 1'b1;
        ctl.data = PAD_MARK_BYTE;
        ctl.start = (fill == LAST_SLOT);
        fill_next = fill + 6'd1;
      end
      ST_PAD_ZERO: begin
        if (fill != LEN_START) begin
          ctl.shift = 1'b1;
          ctl.start = (fill == LAST_SLOT);
          fill_next = fill + 6'd1;
        end
      end
      ST_PAD_LEN: begin
        ctl.shift = 1'b1;
        ctl.data = len[63:56];
        ctl.start = (fill == LAST_SLOT);
        fill_next = fill + 6'd1;
        len_next = {len[55:0], 8'h00};
      end
      ST_FLUSH: begin
        if (!out_busy) begin
          out_load = 1'b1;
          ctl.init = 1'b1;
          blocks_next = '0;
          fill_next = '0;
        end
      end
      default: ctl = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      ret <= ST_IDLE;
      fill <= '0;
      blocks <= '0;
    end else begin
      state <= state_next;
      ret <= ret_next;
      fill <= fill_next;
      blocks <= blocks_next;
    end
  end

  always_ff @(posedge clk) begin
    len <= len_next;
  end

  sbsh_core u_core (
    .clk   (clk),
    .rst   (rst),
    .ctl   (ctl),
    .done  (core_done),
    .chain (chain)
  );

  sbsh_out u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (out_load),
    .words     (chain),
    .busy      (out_busy),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ----- hw/rtl/sbsh_checker.sv -----
// Port-level checks for the SHA-256 byte hasher, bound to the top level.
module sbsh_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input sbsh_pkg::in_item_t  in_data,
  input logic                out_valid,
  input logic                out_ready,
  input sbsh_pkg::out_item_t out_data
);
  import sbsh_pkg::*;

  // digest words leave in order without gaps
  a_word_seq: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !out_data.last_word) |=>
      (out_valid && out_data.word_index == $past(out_data.word_index) + 3'd1))
    else $error("digest word sequence broken");

  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.last_word == (out_data.word_index == 3'd7)))
    else $error("last_word does not match word_index");

  a_first_word: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> (out_data.word_index == 3'd0))
    else $error("digest does not start at word 0");

  a_finish_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && in_data.kind == KIND_FINISH) |=> !in_ready)
    else $error("finish request did not stall input");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

endmodule

bind sha256_byte_stream_hasher sbsh_checker u_chk (.*);
